// File: rtl/ipi_mbx_pkg.sv
`timescale 1ns / 1ps

package ipi_mbx_pkg;

    localparam int NUM_CORES_DEF = 16;

    localparam logic [15:0] MAILBOX_BASE      = 16'h1000;
    localparam logic [15:0] MAIL_SEND_ADDRESS = 16'h1048;
    localparam logic [15:0] ANY_SEND_ADDRESS  = 16'h1158;
    localparam logic [7:0]  WIN_LEN           = 8'h48;
    localparam logic [7:0]  OFF_BUF           = 8'h20;

    localparam logic [5:0] ROFF_STATUS = 6'h00;
    localparam logic [5:0] ROFF_EN     = 6'h01;
    localparam logic [5:0] ROFF_SET    = 6'h02;
    localparam logic [5:0] ROFF_CLEAR  = 6'h03;
    localparam logic [5:0] ROFF_SEND   = 6'h10;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       snd;
        logic       keep;
        logic [7:0] off;
        logic [7:0] wbyte;
        logic [4:0] vec;
    } byte_cmd_t;

    function automatic logic reg_present(input logic [7:0] b);
        return (b[7:4] == 4'h0) || (b[7:5] == 3'b001);
    endfunction

endpackage

// File: rtl/ipi_mbx_ram.sv
`timescale 1ns / 1ps

module ipi_mbx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ipi_mbx_regs.sv
`timescale 1ns / 1ps

module ipi_mbx_regs import ipi_mbx_pkg::*; #(
    parameter int NUM_CORES = NUM_CORES_DEF,
    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1,
    localparam int LW = $clog2(NUM_CORES + 1),
    localparam int MDEPTH = NUM_CORES * 8,
    localparam int MAW = $clog2(MDEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  byte_cmd_t     bcmd,
    input  logic [CW-1:0] core,
    input  logic [LW-1:0] live,
    output logic [7:0]    rbyte,
    output logic [15:0]   irq
);

    logic [31:0]     status_reg [NUM_CORES];
    logic [31:0]     enable_reg [NUM_CORES];
    logic [MDEPTH-1:0] mvalid_reg;

    logic [MAW-1:0] maddr;
    logic [5:0]     roff;
    logic           is_mbx;
    logic [31:0]    ram_rdata;
    logic [31:0]    mword;
    logic [31:0]    cur_word;
    logic [4:0]     sh;
    logic [7:0]     wb;
    logic [31:0]    wmask;
    logic [31:0]    wval;
    logic           ram_we;
    logic [31:0]    ram_wdata;

    assign maddr  = MAW'({core, bcmd.off[4:2]});
    assign roff   = bcmd.off[7:2];
    assign is_mbx = (roff[5:3] == 3'b001);
    assign mword  = mvalid_reg[maddr] ? ram_rdata : 32'h0;
    assign sh     = {bcmd.off[1:0], 3'b000};

    always_comb
    begin
        case (roff)
            ROFF_STATUS: cur_word = status_reg[core];
            ROFF_EN:     cur_word = enable_reg[core];
            default:     cur_word = is_mbx ? mword : 32'h0;
        endcase
    end

    assign rbyte     = 8'(cur_word >> sh);
    assign wb        = bcmd.keep ? rbyte : bcmd.wbyte;
    assign wmask     = 32'hff << sh;
    assign wval      = {24'h0, wb} << sh;
    assign ram_we    = bcmd.wr && is_mbx;
    assign ram_wdata = (mword & ~wmask) | wval;

    ipi_mbx_ram #(
        .WIDTH (32),
        .DEPTH (MDEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (maddr),
        .wdata (ram_wdata),
        .re    (bcmd.rd),
        .raddr (maddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CORES; c++)
            begin
                status_reg[c] <= 32'h0;
                enable_reg[c] <= 32'h0;
            end
            mvalid_reg <= '0;
        end
        else
        begin
            if (bcmd.snd)
            begin
                status_reg[core] <= status_reg[core] | (32'h1 << bcmd.vec);
            end
            else if (bcmd.wr)
            begin
                case (roff)
                    ROFF_EN:    enable_reg[core] <= (enable_reg[core] & ~wmask) | wval;
                    ROFF_SET:   status_reg[core] <= status_reg[core] | wval;
                    ROFF_CLEAR: status_reg[core] <= status_reg[core] & ~wval;
                    default:    ;
                endcase
            end
            if (ram_we)
            begin
                mvalid_reg[maddr] <= 1'b1;
            end
        end
    end

    for (genvar g = 0; g < 16; g++)
    begin : g_irq
        if (g < NUM_CORES)
        begin : g_on
            assign irq[g] = (32'(live) > 32'(g)) && ((status_reg[g] & enable_reg[g]) != 32'h0);
        end
        else
        begin : g_off
            assign irq[g] = 1'b0;
        end
    end

endmodule

// File: rtl/ipi_mbx_ctrl.sv
`timescale 1ns / 1ps

module ipi_mbx_ctrl import ipi_mbx_pkg::*; #(
    parameter int NUM_CORES = NUM_CORES_DEF,
    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1,
    localparam int LW = $clog2(NUM_CORES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,
    input  logic [87:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic          m_tuser,
    output logic [79:0]   m_tdata,
    input  logic [LW-1:0] live,
    output byte_cmd_t     bcmd,
    output logic [CW-1:0] core,
    input  logic [7:0]    rbyte,
    input  logic [15:0]   irq
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEND = 3'd1;
    localparam logic [2:0] S_BRD  = 3'd2;
    localparam logic [2:0] S_BWR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg;
    logic [CW-1:0] core_reg;
    logic [7:0]    off_reg;
    logic [3:0]    n_reg;
    logic [2:0]    idx_reg;
    logic [63:0]   data_reg;
    logic [3:0]    keep_reg;
    logic          wr_reg;
    logic          act_reg;
    logic          chk_reg;
    logic          um_reg;
    logic [4:0]    vec_reg;
    logic [63:0]   rd_reg;
    logic          m_valid_reg;
    logic [79:0]   m_data_reg;
    logic          m_um_reg;

    logic        in_cmd;
    logic [3:0]  in_req;
    logic [15:0] in_addr;
    logic [3:0]  in_bytes;
    logic [63:0] in_wd;
    logic [3:0]  n_clamp;
    logic        live_req;
    logic [9:0]  tgt;
    logic        tgt_ok;
    logic        win;
    logic [7:0]  off;
    logic        win2;
    logic [7:0]  off2;
    logic [31:0] merged;
    logic        mtgt_ok;
    logic        accept;
    logic        last_byte;

    logic [2:0]  d_state;
    logic [9:0]  d_core;
    logic [7:0]  d_off;
    logic [3:0]  d_n;
    logic [63:0] d_data;
    logic [3:0]  d_keep;
    logic        d_act;
    logic        d_chk;
    logic        d_um;
    logic [4:0]  d_vec;

    assign in_cmd   = s_tuser;
    assign in_req   = s_tdata[3:0];
    assign in_addr  = s_tdata[19:4];
    assign in_bytes = s_tdata[23:20];
    assign in_wd    = s_tdata[87:24];

    assign n_clamp  = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
    assign live_req = 8'(in_req) < 8'(live);
    assign tgt      = in_wd[25:16];
    assign tgt_ok   = 11'(tgt) < 11'(live);
    assign win      = (in_addr >= MAILBOX_BASE) && ((in_addr - MAILBOX_BASE) < 16'(WIN_LEN));
    assign off      = 8'(in_addr - MAILBOX_BASE);
    assign win2     = (in_wd[15:0] >= MAILBOX_BASE)
                      && ((in_wd[15:0] - MAILBOX_BASE) < 16'(WIN_LEN));
    assign off2     = 8'(in_wd[15:0] - MAILBOX_BASE);

    for (genvar i = 0; i < 4; i++)
    begin : g_merge
        assign merged[8*i +: 8] = in_wd[27+i] ? 8'h0 : in_wd[32+8*i +: 8];
    end
    assign mtgt_ok = 11'(merged[25:16]) < 11'(live);

    always_comb
    begin
        d_state = S_DONE;
        d_core  = 10'(in_req);
        d_off   = off;
        d_n     = n_clamp;
        d_data  = in_wd;
        d_keep  = 4'h0;
        d_act   = live_req;
        d_chk   = 1'b1;
        d_um    = 1'b0;
        d_vec   = in_wd[4:0];
        if (win)
        begin
            if (in_cmd && (off[7:2] == ROFF_SEND))
            begin
                d_chk  = 1'b0;
                d_core = tgt;
                if (live_req && tgt_ok)
                begin
                    d_state = S_SEND;
                end
            end
            else if (n_clamp != 4'd0)
            begin
                d_state = S_BRD;
            end
        end
        else if (in_cmd && (in_addr == MAIL_SEND_ADDRESS) && (n_clamp == 4'd8))
        begin
            d_chk  = 1'b0;
            d_act  = 1'b1;
            d_core = tgt;
            d_off  = OFF_BUF | {3'b000, in_wd[4:2], 2'b00};
            d_n    = 4'd4;
            d_data = {32'h0, in_wd[63:32]};
            d_keep = in_wd[30:27];
            if (live_req && tgt_ok)
            begin
                d_state = S_BRD;
            end
        end
        else if (in_cmd && (in_addr == ANY_SEND_ADDRESS) && (n_clamp == 4'd8))
        begin
            d_chk  = 1'b0;
            d_act  = 1'b1;
            d_core = tgt;
            d_off  = off2;
            d_n    = 4'd4;
            d_data = {32'h0, in_wd[63:32]};
            d_keep = in_wd[30:27];
            if (live_req && tgt_ok && win2)
            begin
                if (off2[7:2] == ROFF_SEND)
                begin
                    d_core = merged[25:16];
                    d_vec  = merged[4:0];
                    if (mtgt_ok)
                    begin
                        d_state = S_SEND;
                    end
                end
                else
                begin
                    d_state = S_BRD;
                end
            end
        end
        else
        begin
            d_um = 1'b1;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_byte = (idx_reg == 3'(n_reg - 4'd1));

    assign bcmd.rd    = (state_reg == S_BRD);
    assign bcmd.wr    = (state_reg == S_BWR) && act_reg && wr_reg;
    assign bcmd.snd   = (state_reg == S_SEND);
    assign bcmd.keep  = keep_reg[0];
    assign bcmd.off   = off_reg;
    assign bcmd.wbyte = data_reg[7:0];
    assign bcmd.vec   = vec_reg;
    assign core       = core_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_um_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= d_state;
                    end
                end
                S_SEND:
                begin
                    state_reg <= S_DONE;
                end
                S_BRD:
                begin
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    state_reg <= last_byte ? S_DONE : S_BRD;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            core_reg <= CW'(d_core);
            off_reg  <= d_off;
            n_reg    <= d_n;
            idx_reg  <= 3'd0;
            data_reg <= d_data;
            keep_reg <= d_keep;
            wr_reg   <= in_cmd;
            act_reg  <= d_act;
            chk_reg  <= d_chk;
            um_reg   <= d_um;
            vec_reg  <= d_vec;
            rd_reg   <= 64'h0;
        end
        else if (state_reg == S_BWR)
        begin
            if (act_reg && !wr_reg)
            begin
                rd_reg[{idx_reg, 3'b000} +: 8] <= rbyte;
            end
            if (chk_reg && !reg_present(off_reg))
            begin
                um_reg <= 1'b1;
            end
            off_reg  <= off_reg + 8'd1;
            idx_reg  <= idx_reg + 3'd1;
            data_reg <= data_reg >> 8;
            keep_reg <= keep_reg >> 1;
        end
        if ((state_reg == S_DONE) && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= {irq, rd_reg};
            m_um_reg   <= um_reg;
        end
    end

    a_wr_snd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(bcmd.wr && bcmd.snd))
        else $error("byte write and send in the same cycle");

    a_bwr_after_brd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BWR) |-> ($past(state_reg) == S_BRD))
        else $error("byte apply without a preceding fetch");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BRD) |-> ((n_reg != 4'd0) && ({1'b0, idx_reg} < n_reg)))
        else $error("byte index beyond access size");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside completion");

endmodule

// File: rtl/ipi_mailbox_controller.sv
`timescale 1ns / 1ps

// Inter-processor interrupt and mailbox controller.
// Slave channel s_*: one register access per beat. s_tuser is the access kind
// (0 read, 1 write); s_tdata carries requester core, address, size and data.
// Master channel m_*: one result beat per access, carrying read data and the
// pending interrupt line of each core; m_tuser flags an unmapped access.
// cfg_*: writes the number of active cores, always ready.
// Accesses are worked one byte at a time, each byte in two steps (fetch, then
// apply) through the mailbox RAM's registered read port.
// The next access is accepted as soon as the previous result is loaded into
// the output register, even if that result is still waiting.
// When the receiver stalls, the result is held and the following access
// waits in its completion step until the output register frees up.
// Reset clears status, enable and all mailbox words (through per-word valid
// bits) and sets the active core count to 16; no clearing pass is needed.
module ipi_mailbox_controller import ipi_mbx_pkg::*; #(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,     // cmd
    input  logic [87:0] s_tdata,     // requester_core, access_address, access_bytes, write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,     // unmapped
    output logic [79:0] m_tdata,     // read_data, irq_pending
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int LW = $clog2(NUM_CORES + 1);

    logic [4:0]    active_reg;
    logic [LW-1:0] live;
    byte_cmd_t     bcmd;
    logic [CW-1:0] core;
    logic [7:0]    rbyte;
    logic [15:0]   irq;

    assign cfg_ready = 1'b1;
    assign live = (32'(active_reg) > NUM_CORES) ? LW'(NUM_CORES) : LW'(active_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    ipi_mbx_ctrl #(
        .NUM_CORES (NUM_CORES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .live     (live),
        .bcmd     (bcmd),
        .core     (core),
        .rbyte    (rbyte),
        .irq      (irq)
    );

    ipi_mbx_regs #(
        .NUM_CORES (NUM_CORES)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .bcmd  (bcmd),
        .core  (core),
        .live  (live),
        .rbyte (rbyte),
        .irq   (irq)
    );

endmodule
